// ===== rtl/separable_gaussian_blur_3tap_top_macros.svh =====
// assertion helpers shared by the blur rtl
`ifndef SEPARABLE_GAUSSIAN_BLUR_3TAP_TOP_MACROS_SVH
`define SEPARABLE_GAUSSIAN_BLUR_3TAP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define SGB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
// checked on every edge, reset included
`define SGB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define SGB_ASSERT(lbl, clk, rstn, prop)
`define SGB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/sgb_pkg.sv =====
package sgb_pkg;

  localparam int unsigned SGB_MAX_WIDTH   = 1024;
  localparam int unsigned SGB_H_FRAC_BITS = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SIDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MODE    = 3'd4;

  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd1024;
  localparam logic [15:0] RST_WEIGHT_CENTER = 16'd29622;
  localparam logic [15:0] RST_WEIGHT_SIDE   = 16'd17957;
  localparam logic        RST_ROUND_MODE    = 1'b1;

  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic [15:0] weight_center;
    logic [15:0] weight_side;
    logic        round_mode;
  } sgb_cfg_t;

  // one column of work handed from the front to the back
  typedef struct packed {
    logic       drain;
    logic       has_l;
    logic       has_r;
    logic       has_t;
    logic       emit;
    logic       run_last;
    logic       frame_last;
    logic [7:0] l;
    logic [7:0] c;
    logic [7:0] r;
  } sgb_job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_HMUL0,
    BK_HMUL1,
    BK_HSTART,
    BK_HDIV,
    BK_VMUL0,
    BK_VMUL1,
    BK_VSTART,
    BK_VDIV,
    BK_VOUT
  } sgb_back_state_e;

endpackage

// ===== rtl/sgb_if.sv =====
interface sgb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink (input valid, input op, input pixel, output ready);
endinterface

interface sgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blurred;
  logic       run_last;
  logic       frame_last;

  modport source (output valid, output blurred, output run_last, output frame_last, input ready);
  modport sink (input valid, input blurred, input run_last, input frame_last, output ready);
endinterface

// ===== rtl/sgb_ram.sv =====
module sgb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/sgb_fifo.sv =====
`include "separable_gaussian_blur_3tap_top_macros.svh"

module sgb_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNTW'(DEPTH));

  `SGB_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o)
  `SGB_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o)
  `SGB_ASSERT_ALWAYS(a_count_bound, clk_i, count_q <= CNTW'(DEPTH))
endmodule

// ===== rtl/sgb_div.sv =====
module sgb_div #(
  parameter int unsigned NW  = 35,
  parameter int unsigned DVW = 26,
  parameter int unsigned QW  = 16,
  localparam int unsigned CNTW = $clog2(QW + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [QW-1:0]  quot_o
);
  logic [DVW-1:0]  rem_q, rem_d;
  logic [DVW-1:0]  dv_q;
  logic [QW-1:0]   sh_q, sh_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DVW:0]    trial;
  logic            take;

  // restoring division, one quotient bit a cycle; quotient known to fit QW bits
  assign trial = {rem_q, sh_q[QW-1]};
  assign take  = (trial >= {1'b0, dv_q});

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = DVW'(dividend_i[NW-1:QW]);
      sh_d   = dividend_i[QW-1:0];
      cnt_d  = CNTW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? DVW'(trial - {1'b0, dv_q}) : trial[DVW-1:0];
      sh_d  = {sh_q[QW-2:0], take};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) begin
      dv_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = sh_q;
endmodule

// ===== rtl/sgb_front.sv =====
module sgb_front #(
  parameter int unsigned MAX_WIDTH = sgb_pkg::SGB_MAX_WIDTH,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgb_pkg::sgb_cfg_t cfg_i,
  sgb_in_if.sink           in_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output sgb_pkg::sgb_job_t q_job_o,
  output logic [CW-1:0]    q_col_o
);
  import sgb_pkg::*;

  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0] column_pos_q, column_pos_d, drain_pos_q, drain_pos_d;
  logic [11:0]   row_pos_q, row_pos_d;
  logic [7:0]    pixel_prev_q, pixel_prev_d, pixel_prev2_q, pixel_prev2_d;
  logic          draining_q, draining_d;
  logic          pend_q, pend_d;
  sgb_job_t      pend_job_q, job_a, job_b, job_d;
  logic [CW-1:0] pend_col_q;

  logic [EW-1:0] eff_w, w_last;
  logic [11:0]   h_last;
  logic          col_ge1, col_ge2, row_ge1, row_ge2, row_end, drain_end;
  logic          accept, is_drain, split;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(cfg_i.image_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      h_last = '0;
    end else if (cfg_i.image_height > MAX_HEIGHT) begin
      h_last = 12'(MAX_HEIGHT - 13'd1);
    end else begin
      h_last = 12'(cfg_i.image_height - 13'd1);
    end
  end

  assign w_last    = eff_w - EW'(1);
  assign col_ge1   = (column_pos_q != '0);
  assign col_ge2   = (EW'(column_pos_q) >= EW'(2));
  assign row_ge1   = (row_pos_q != '0);
  assign row_ge2   = (row_pos_q >= 12'd2);
  assign row_end   = (EW'(column_pos_q) >= w_last);
  assign drain_end = (EW'(drain_pos_q) >= w_last);

  assign in_i.ready = !pend_q && !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_drain   = (in_i.op == OP_DRAIN);
  // row-end pixel with a left neighbour completes two columns
  assign split      = accept && !is_drain && !draining_q && col_ge1 && row_end;

  always_comb begin
    job_a            = '0;
    job_a.has_l      = col_ge2;
    job_a.has_r      = 1'b1;
    job_a.has_t      = row_ge2;
    job_a.emit       = row_ge1;
    job_a.run_last   = !row_end;
    job_a.l          = pixel_prev2_q;
    job_a.c          = pixel_prev_q;
    job_a.r          = in_i.pixel;

    job_b            = '0;
    job_b.has_l      = col_ge1;
    job_b.has_t      = row_ge2;
    job_b.emit       = row_ge1;
    job_b.run_last   = 1'b1;
    job_b.l          = pixel_prev_q;
    job_b.c          = in_i.pixel;

    job_d            = '0;
    job_d.drain      = 1'b1;
    job_d.has_t      = row_ge1;
    job_d.emit       = 1'b1;
    job_d.run_last   = 1'b1;
    job_d.frame_last = drain_end;
  end

  always_comb begin
    q_push_o = 1'b0;
    q_job_o  = job_a;
    q_col_o  = column_pos_q - CW'(1);
    if (pend_q) begin
      q_push_o = !q_full_i;
      q_job_o  = pend_job_q;
      q_col_o  = pend_col_q;
    end else if (accept) begin
      if (is_drain) begin
        q_push_o = draining_q;
        q_job_o  = job_d;
        q_col_o  = drain_pos_q;
      end else if (!draining_q) begin
        if (col_ge1) begin
          q_push_o = 1'b1;
        end else if (row_end) begin
          q_push_o = 1'b1;
          q_job_o  = job_b;
          q_col_o  = column_pos_q;
        end
      end
    end
  end

  always_comb begin
    column_pos_d  = column_pos_q;
    drain_pos_d   = drain_pos_q;
    row_pos_d     = row_pos_q;
    pixel_prev_d  = pixel_prev_q;
    pixel_prev2_d = pixel_prev2_q;
    draining_d    = draining_q;
    pend_d        = pend_q;
    if (pend_q && !q_full_i) begin
      pend_d = 1'b0;
    end
    if (split) begin
      pend_d = 1'b1;
    end
    if (accept && is_drain && draining_q) begin
      if (drain_end) begin
        draining_d    = 1'b0;
        drain_pos_d   = '0;
        row_pos_d     = '0;
        column_pos_d  = '0;
        pixel_prev_d  = '0;
        pixel_prev2_d = '0;
      end else begin
        drain_pos_d = drain_pos_q + CW'(1);
      end
    end else if (accept && !is_drain && !draining_q) begin
      if (row_end) begin
        column_pos_d  = '0;
        pixel_prev_d  = '0;
        pixel_prev2_d = '0;
        if (row_pos_q >= h_last) begin
          draining_d  = 1'b1;
          drain_pos_d = '0;
        end else begin
          row_pos_d = row_pos_q + 12'd1;
        end
      end else begin
        column_pos_d  = column_pos_q + CW'(1);
        pixel_prev2_d = pixel_prev_q;
        pixel_prev_d  = in_i.pixel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_pos_q  <= '0;
      drain_pos_q   <= '0;
      row_pos_q     <= '0;
      pixel_prev_q  <= '0;
      pixel_prev2_q <= '0;
      draining_q    <= 1'b0;
      pend_q        <= 1'b0;
    end else begin
      column_pos_q  <= column_pos_d;
      drain_pos_q   <= drain_pos_d;
      row_pos_q     <= row_pos_d;
      pixel_prev_q  <= pixel_prev_d;
      pixel_prev2_q <= pixel_prev2_d;
      draining_q    <= draining_d;
      pend_q        <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (split) begin
      pend_job_q <= job_b;
      pend_col_q <= column_pos_q;
    end
  end
endmodule

// ===== rtl/sgb_back.sv =====
`include "separable_gaussian_blur_3tap_top_macros.svh"

module sgb_back #(
  parameter int unsigned MAX_WIDTH   = sgb_pkg::SGB_MAX_WIDTH,
  parameter int unsigned H_FRAC_BITS = sgb_pkg::SGB_H_FRAC_BITS,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgb_pkg::sgb_cfg_t cfg_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  sgb_pkg::sgb_job_t q_job_i,
  input  logic [CW-1:0]     q_col_i,
  sgb_out_if.source         out_o
);
  import sgb_pkg::*;

  localparam int unsigned HW  = 8 + H_FRAC_BITS;
  localparam int unsigned QW  = (HW > 9) ? HW : 9;
  localparam int unsigned AW  = 26 + H_FRAC_BITS;
  localparam int unsigned NW  = 27 + H_FRAC_BITS;
  localparam int unsigned DVW = 18 + H_FRAC_BITS;

  sgb_back_state_e state_q, state_d;
  sgb_job_t        job_q;
  logic [CW-1:0]   col_q;
  logic [AW-1:0]   acc_q, acc_d;
  logic            acc_en;
  logic [HW-1:0]   h_q;
  logic [7:0]      res_q;
  logic            res_en, ram_we, out_load;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_blurred_q;
  logic            out_run_last_q, out_frame_last_q;

  logic [HW-1:0]   older_rd, newer_rd;

  logic            div_start, div_busy, div_done;
  logic [NW-1:0]   div_dividend, h_dividend, v_dividend;
  logic [DVW-1:0]  div_divisor, den_h, den_v;
  logic [QW-1:0]   div_quot;

  logic [8:0]      h_side;
  logic [23:0]     hprod0;
  logic [24:0]     hprod1;
  logic [17:0]     hden, vden;
  logic [HW-1:0]   v_top, v_bot;
  logic [HW:0]     v_side;
  logic [HW+15:0]  vprod0;
  logic [HW+16:0]  vprod1;
  logic [AW-1:0]   num_h, num_v;

  // horizontal mean terms
  assign h_side = (job_q.has_l ? {1'b0, job_q.l} : 9'd0)
                + (job_q.has_r ? {1'b0, job_q.r} : 9'd0);
  assign hprod0 = {16'd0, job_q.c} * {8'd0, cfg_i.weight_center};
  assign hprod1 = {16'd0, h_side} * {9'd0, cfg_i.weight_side};
  assign hden   = {2'b00, cfg_i.weight_center}
                + (job_q.has_l ? {2'b00, cfg_i.weight_side} : 18'd0)
                + (job_q.has_r ? {2'b00, cfg_i.weight_side} : 18'd0);

  // vertical mean terms; drain words have no row below
  assign v_top  = job_q.has_t ? older_rd : '0;
  assign v_bot  = job_q.drain ? '0 : h_q;
  assign v_side = {1'b0, v_top} + {1'b0, v_bot};
  assign vprod0 = {16'd0, newer_rd} * {{HW{1'b0}}, cfg_i.weight_center};
  assign vprod1 = {16'd0, v_side} * {{(HW + 1){1'b0}}, cfg_i.weight_side};
  assign vden   = {2'b00, cfg_i.weight_center}
                + (job_q.has_t ? {2'b00, cfg_i.weight_side} : 18'd0)
                + (job_q.drain ? 18'd0 : {2'b00, cfg_i.weight_side});

  // zero weight sum falls back to the center sample
  assign num_h      = (hden == '0) ? AW'(job_q.c) : acc_q;
  assign den_h      = (hden == '0) ? DVW'(1) : DVW'(hden);
  assign h_dividend = (NW'(num_h) << H_FRAC_BITS) + NW'(den_h >> 1);
  assign num_v      = (vden == '0) ? AW'(newer_rd) : acc_q;
  assign den_v      = ((vden == '0) ? DVW'(1) : DVW'(vden)) << H_FRAC_BITS;
  assign v_dividend = NW'(num_v) + (cfg_i.round_mode ? NW'(den_v >> 1) : NW'(0));

  assign div_start    = (state_q == BK_HSTART) || (state_q == BK_VSTART);
  assign div_dividend = (state_q == BK_VSTART) ? v_dividend : h_dividend;
  assign div_divisor  = (state_q == BK_VSTART) ? den_v : den_h;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = q_job_i.drain ? BK_VMUL0 : BK_HMUL0;
        end
      end
      BK_HMUL0:  state_d = BK_HMUL1;
      BK_HMUL1:  state_d = BK_HSTART;
      BK_HSTART: state_d = BK_HDIV;
      BK_HDIV: begin
        if (div_done) begin
          state_d = job_q.emit ? BK_VMUL0 : BK_IDLE;
        end
      end
      BK_VMUL0:  state_d = BK_VMUL1;
      BK_VMUL1:  state_d = BK_VSTART;
      BK_VSTART: state_d = BK_VDIV;
      BK_VDIV: begin
        if (div_done) begin
          state_d = BK_VOUT;
        end
      end
      BK_VOUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    acc_en   = 1'b0;
    acc_d    = acc_q;
    ram_we   = 1'b0;
    res_en   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE:  q_pop_o = !q_empty_i;
      BK_HMUL0: begin
        acc_en = 1'b1;
        acc_d  = AW'(hprod0);
      end
      BK_HMUL1: begin
        acc_en = 1'b1;
        acc_d  = acc_q + AW'(hprod1);
      end
      BK_HDIV:  ram_we = div_done;
      BK_VMUL0: begin
        acc_en = 1'b1;
        acc_d  = AW'(vprod0);
      end
      BK_VMUL1: begin
        acc_en = 1'b1;
        acc_d  = acc_q + AW'(vprod1);
      end
      BK_VDIV:  res_en = div_done;
      BK_VOUT:  out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
      col_q <= q_col_i;
    end
    if (acc_en) begin
      acc_q <= acc_d;
    end
    if (ram_we) begin
      h_q <= div_quot[HW-1:0];
    end
    if (res_en) begin
      res_q <= (div_quot > QW'(255)) ? 8'hFF : div_quot[7:0];
    end
    if (out_load) begin
      out_blurred_q    <= res_q;
      out_run_last_q   <= job_q.run_last;
      out_frame_last_q <= job_q.frame_last;
    end
  end

  // older row takes what the newer row held; newer row takes the fresh value
  sgb_ram #(.WIDTH(HW), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (newer_rd),
    .re_i    (q_pop_o),
    .raddr_i (q_col_i),
    .rdata_o (older_rd)
  );

  sgb_ram #(.WIDTH(HW), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (div_quot[HW-1:0]),
    .re_i    (q_pop_o),
    .raddr_i (q_col_i),
    .rdata_o (newer_rd)
  );

  sgb_div #(.NW(NW), .DVW(DVW), .QW(QW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.blurred    = out_blurred_q;
  assign out_o.run_last   = out_run_last_q;
  assign out_o.frame_last = out_frame_last_q;

  `SGB_ASSERT(a_div_start_free, clk_i, rst_ni, div_start |-> !div_busy)
  `SGB_ASSERT(a_div_done_state, clk_i, rst_ni, div_done |-> (state_q == BK_HDIV || state_q == BK_VDIV))
  `SGB_ASSERT(a_div_wait_busy, clk_i, rst_ni, (state_q == BK_VDIV) |-> (div_busy || div_done))
endmodule

// ===== rtl/separable_gaussian_blur_3tap_top.sv =====
// 3x3 separable gaussian blur over an 8-bit raster stream. a front stage takes
// one word per cycle unless the queue is full or a split job is pending, and
// turns each pixel into zero, one or two column jobs; a four-entry queue feeds
// the back stage, which runs one column at a time through a single iterative
// divider (one quotient bit per cycle) shared by the horizontal and vertical
// passes. a first-row column runs only the horizontal half. results lag one
// row; after the last row, one drain word per pixel of that row flushes it
// out.
// config is taken at any time but should only change while the block is idle.
module separable_gaussian_blur_3tap_top #(
  parameter int unsigned MAX_WIDTH   = sgb_pkg::SGB_MAX_WIDTH,
  parameter int unsigned H_FRAC_BITS = sgb_pkg::SGB_H_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sgb_in_if.sink                         in_i,
  sgb_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sgb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned JW = $bits(sgb_job_t) + CW;

  sgb_cfg_t      cfg_q;
  logic          q_push, q_pop, q_empty, q_full;
  sgb_job_t      push_job, pop_job;
  logic [CW-1:0] push_col, pop_col;
  logic [JW-1:0] q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= RST_IMAGE_WIDTH;
      cfg_q.image_height  <= RST_IMAGE_HEIGHT;
      cfg_q.weight_center <= RST_WEIGHT_CENTER;
      cfg_q.weight_side   <= RST_WEIGHT_SIDE;
      cfg_q.round_mode    <= RST_ROUND_MODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i[12:0];
        CFG_WEIGHT_CENTER: cfg_q.weight_center <= cfg_data_i;
        CFG_WEIGHT_SIDE:   cfg_q.weight_side   <= cfg_data_i;
        CFG_ROUND_MODE:    cfg_q.round_mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sgb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (push_job),
    .q_col_o  (push_col)
  );

  sgb_fifo #(.WIDTH(JW), .DEPTH(4)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({push_col, push_job}),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign {pop_col, pop_job} = q_rdata;

  sgb_back #(.MAX_WIDTH(MAX_WIDTH), .H_FRAC_BITS(H_FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .q_job_i   (pop_job),
    .q_col_i   (pop_col),
    .out_o     (out_o)
  );
endmodule
